// ----- design/mfps_pkg.sv -----
package mfps_pkg;

    localparam int SUM_W      = 32;
    localparam int NUM_ROWS_W = 16;
    localparam int NUM_COLS_W = 9;
    localparam int CFG_DATA_W = 32;
    localparam int CFG_ADDR_W = 3;

    localparam logic [NUM_ROWS_W-1:0] NUM_ROWS_RST = NUM_ROWS_W'(4);
    localparam logic [NUM_COLS_W-1:0] NUM_COLS_RST = NUM_COLS_W'(4);

    localparam logic signed [SUM_W-1:0] SUM_MAX = {1'b0, {(SUM_W-1){1'b1}}};
    localparam logic signed [SUM_W-1:0] SUM_MIN = {1'b1, {(SUM_W-1){1'b0}}};

    // Register select, taken from paddr bit 2.
    typedef enum logic {
        REG_NUM_ROWS = 1'b0,
        REG_NUM_COLS = 1'b1
    } reg_sel_t;

    typedef logic signed [SUM_W-1:0] sum_t;

    // Broadcast to every cell of the row line.
    typedef struct packed {
        logic shift;
        sum_t sum;
    } cell_ctrl_t;

endpackage

// ----- design/mfps_cell.sv -----
module mfps_cell (
    input  logic               aclk,
    input  mfps_pkg::cell_ctrl_t ctrl,
    input  logic               is_tail,
    input  mfps_pkg::sum_t     neigh_in,
    output mfps_pkg::sum_t     val_out
);
    import mfps_pkg::*;

    sum_t val_reg;
    sum_t val_next;

    // The tail cell takes the fresh sum; every other cell takes its right neighbor.
    always_comb begin
        val_next = is_tail ? ctrl.sum : neigh_in;
    end

    always_ff @(posedge aclk) begin
        if (ctrl.shift) begin
            val_reg <= val_next;
        end
    end

    assign val_out = val_reg;

endmodule

// ----- design/max_falling_path_sum.sv -----
// Maximum falling path sum over a matrix that streams in row-major order, one
// signed element per s_ beat. The previous row lives in a line of MAX_COLS cells
// that shifts by one on every accepted beat; the newest sum enters at the cell
// set by num_cols, so cell 0 always holds the entry straight above the current
// element and cell 1 the one to its right. The block takes one element per clock
// cycle with no bubbles, limited only by m_tready when a result is pending; the
// single result (the saturated maximum over the last row) is on m_ in the cycle
// after the final element is accepted. num_rows and num_cols sit at APB byte
// addresses 0 and 4, to be written only while no problem is in progress; the
// block does not check. Zero is taken as one, num_cols > MAX_COLS as MAX_COLS.
module max_falling_path_sum #(
    parameter int MAX_COLS   = 256,
    parameter int DATA_WIDTH = 16,
    localparam int TDATA_W   = ((DATA_WIDTH + 7) / 8) * 8
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    // APB configuration port
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [mfps_pkg::CFG_ADDR_W-1:0]   paddr,
    input  logic [mfps_pkg::CFG_DATA_W-1:0]   pwdata,
    output logic [mfps_pkg::CFG_DATA_W-1:0]   prdata,
    output logic                              pready,
    // Element stream
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [TDATA_W-1:0]                s_tdata,  // cell_value
    // Result stream
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [mfps_pkg::SUM_W-1:0]        m_tdata   // path_max
);
    import mfps_pkg::*;

    localparam int IDX_W = $clog2(MAX_COLS);
    localparam int CNT_W = $clog2(MAX_COLS + 1);
    localparam int EXT_W = (CNT_W > NUM_COLS_W) ? CNT_W : NUM_COLS_W;
    localparam logic [EXT_W-1:0] MAX_COLS_EXT = EXT_W'(MAX_COLS);

    // Configuration registers
    logic [NUM_ROWS_W-1:0] num_rows_reg;
    logic [NUM_COLS_W-1:0] num_cols_reg;
    reg_sel_t              cfg_sel;
    logic                  cfg_write;

    assign pready    = 1'b1;
    assign cfg_sel   = reg_sel_t'(paddr[2]);
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            num_rows_reg <= NUM_ROWS_RST;
            num_cols_reg <= NUM_COLS_RST;
        end else if (cfg_write) begin
            unique case (cfg_sel)
                REG_NUM_ROWS: num_rows_reg <= pwdata[NUM_ROWS_W-1:0];
                REG_NUM_COLS: num_cols_reg <= pwdata[NUM_COLS_W-1:0];
                default:      num_rows_reg <= num_rows_reg;
            endcase
        end
    end

    always_comb begin
        unique case (cfg_sel)
            REG_NUM_ROWS: prdata = CFG_DATA_W'(num_rows_reg);
            REG_NUM_COLS: prdata = CFG_DATA_W'(num_cols_reg);
            default:      prdata = '0;
        endcase
    end

    // Effective sizes
    logic [EXT_W-1:0]      cols_ext;
    logic [CNT_W-1:0]      ncols_eff;
    logic [IDX_W-1:0]      tail_idx;
    logic [NUM_ROWS_W-1:0] nrows_eff;

    always_comb begin
        cols_ext = EXT_W'(num_cols_reg);
        if (cols_ext == '0) begin
            ncols_eff = CNT_W'(1);
        end else if (cols_ext > MAX_COLS_EXT) begin
            ncols_eff = CNT_W'(MAX_COLS);
        end else begin
            ncols_eff = cols_ext[CNT_W-1:0];
        end
        tail_idx  = IDX_W'(ncols_eff - CNT_W'(1));
        nrows_eff = (num_rows_reg == '0) ? NUM_ROWS_W'(1) : num_rows_reg;
    end

    // Control state
    logic [IDX_W-1:0]      col_reg, col_next;
    logic [NUM_ROWS_W-1:0] row_reg, row_next;
    sum_t                  best_reg, best_next;
    logic                  out_valid_reg, out_valid_next;
    sum_t                  out_reg, out_next;
    sum_t                  held_reg;

    logic                  accept;
    logic [IDX_W-1:0]      col_eff;
    logic                  last_col;
    logic                  last_row;

    sum_t                  cells [MAX_COLS];
    logic [MAX_COLS-1:0]   tail_hit;
    cell_ctrl_t            ctrl;

    logic signed [DATA_WIDTH-1:0] cell_value;
    sum_t                  cell_ext;
    sum_t                  above_best;
    logic signed [SUM_W:0] wide_sum;
    sum_t                  new_sum;
    sum_t                  cand;

    assign s_tready = !out_valid_reg || m_tready;
    assign accept   = s_tvalid && s_tready;

    assign cell_value = s_tdata[DATA_WIDTH-1:0];
    assign cell_ext   = SUM_W'(cell_value);

    always_comb begin
        col_eff  = (CNT_W'(col_reg) >= ncols_eff) ? tail_idx : col_reg;
        last_col = (col_eff == tail_idx);
        last_row = ({1'b0, row_reg} + (NUM_ROWS_W + 1)'(1)) >= {1'b0, nrows_eff};
    end

    // Best of the neighbors above; straight up always exists.
    always_comb begin
        above_best = cells[0];
        if ((col_eff != '0) && (held_reg > above_best)) begin
            above_best = held_reg;
        end
        if (!last_col && (cells[1] > above_best)) begin
            above_best = cells[1];
        end
        wide_sum = (SUM_W + 1)'(cell_ext) + (SUM_W + 1)'(above_best);
        if (row_reg == '0) begin
            new_sum = cell_ext;
        end else if (wide_sum[SUM_W] != wide_sum[SUM_W-1]) begin
            new_sum = wide_sum[SUM_W] ? SUM_MIN : SUM_MAX;
        end else begin
            new_sum = wide_sum[SUM_W-1:0];
        end
        cand = (new_sum > best_reg) ? new_sum : best_reg;
    end

    assign ctrl.shift = accept;
    assign ctrl.sum   = new_sum;

    // Row line of cells
    genvar gi;
    generate
        for (gi = 0; gi < MAX_COLS; gi++) begin : g_cell
            sum_t neigh;
            assign tail_hit[gi] = (tail_idx == IDX_W'(gi));
            if (gi == MAX_COLS - 1) begin : g_end
                assign neigh = ctrl.sum;
            end else begin : g_mid
                assign neigh = cells[gi+1];
            end
            mfps_cell u_cell (
                .aclk     (aclk),
                .ctrl     (ctrl),
                .is_tail  (tail_hit[gi]),
                .neigh_in (neigh),
                .val_out  (cells[gi])
            );
        end
    endgenerate

    always_comb begin
        col_next       = col_reg;
        row_next       = row_reg;
        best_next      = best_reg;
        out_valid_next = out_valid_reg && !m_tready;
        out_next       = out_reg;
        if (accept) begin
            if (last_row) begin
                best_next = cand;
            end
            if (!last_col) begin
                col_next = col_eff + IDX_W'(1);
            end else begin
                col_next = '0;
                if (!last_row) begin
                    row_next = row_reg + NUM_ROWS_W'(1);
                end else begin
                    row_next       = '0;
                    best_next      = SUM_MIN;
                    out_next       = cand;
                    out_valid_next = 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col_reg       <= '0;
            row_reg       <= '0;
            best_reg      <= SUM_MIN;
            out_valid_reg <= 1'b0;
        end else begin
            col_reg       <= col_next;
            row_reg       <= row_next;
            best_reg      <= best_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // The old entry above is kept one beat longer as the next column's left diagonal.
    always_ff @(posedge aclk) begin
        out_reg <= out_next;
        if (accept) begin
            held_reg <= cells[0];
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_reg;

endmodule
